@@ sv/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/i2d_pkg.sv @@
// Shared constants and types for the integer to decimal text unit.
package i2d_pkg;

  localparam int unsigned WordW     = 32;
  localparam int unsigned NumDigits = 10;
  localparam int unsigned BcdW      = 4 * NumDigits;
  localparam int unsigned CntW      = $clog2(WordW);
  localparam int unsigned IdxW      = $clog2(NumDigits);
  localparam int unsigned CharW     = 8;
  localparam int unsigned CountW    = 4;

  localparam logic [CharW-1:0] CharZero  = 8'h30;
  localparam logic [CharW-1:0] CharNine  = 8'h39;
  localparam logic [CharW-1:0] CharMinus = 8'h2D;

  // Input kind codes.
  localparam logic KindSigned   = 1'b0;
  localparam logic KindUnsigned = 1'b1;

  // Converted number handed from the converter to the emitter.
  typedef struct packed {
    logic [NumDigits-1:0][3:0] bcd;
    logic                      neg;
  } i2d_num_t;

endpackage

@@ sv/i2d_bcd_conv.sv @@
// Bit-serial binary to BCD converter (shift and add-3), one bit per cycle.
module i2d_bcd_conv import i2d_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             kind_i,
  input  logic [WordW-1:0] value_bits_i,
  output logic             num_valid_o,
  input  logic             num_ready_i,
  output i2d_num_t         num_o
);

  typedef enum logic [2:0] {
    CONV_IDLE = 3'b001,
    CONV_RUN  = 3'b010,
    CONV_HOLD = 3'b100
  } conv_state_e;

  conv_state_e               state_q, state_d;
  logic [CntW-1:0]           cnt_q, cnt_d;
  logic [WordW-1:0]          bin_q, bin_d;
  logic [NumDigits-1:0][3:0] bcd_q, bcd_d;
  logic                      neg_q, neg_d;

  logic                      is_neg;
  logic [WordW-1:0]          mag;
  logic [NumDigits-1:0][3:0] adj;
  logic [BcdW-1:0]           adj_flat;

  // Magnitude of the input word; the most negative value maps onto itself.
  assign is_neg = (kind_i == KindSigned) && value_bits_i[WordW-1];
  assign mag    = is_neg ? WordW'(~value_bits_i + WordW'(1)) : value_bits_i;

  // Add-3 correction on every digit before the shift.
  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      adj[i] = (bcd_q[i] >= 4'd5) ? 4'(bcd_q[i] + 4'd3) : bcd_q[i];
    end
  end
  assign adj_flat = adj;

  // Sequencer
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    bin_d   = bin_q;
    bcd_d   = bcd_q;
    neg_d   = neg_q;
    unique case (state_q)
      CONV_IDLE: begin
        if (in_valid_i) begin
          bin_d   = mag;
          bcd_d   = '0;
          neg_d   = is_neg;
          cnt_d   = '0;
          state_d = CONV_RUN;
        end
      end
      CONV_RUN: begin
        bcd_d = {adj_flat[BcdW-2:0], bin_q[WordW-1]};
        bin_d = {bin_q[WordW-2:0], 1'b0};
        cnt_d = CntW'(cnt_q + CntW'(1));
        if (cnt_q == CntW'(WordW - 1)) begin
          state_d = CONV_HOLD;
        end
      end
      CONV_HOLD: begin
        if (num_ready_i) begin
          state_d = CONV_IDLE;
        end
      end
      default: state_d = CONV_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CONV_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Datapath shift registers
  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
    neg_q <= neg_d;
  end

  assign in_ready_o  = (state_q == CONV_IDLE);
  assign num_valid_o = (state_q == CONV_HOLD);
  assign num_o.bcd   = bcd_q;
  assign num_o.neg   = neg_q;

endmodule

@@ sv/i2d_char_emit.sv @@
// Character emitter: sign, then digits from the most significant nonzero one.
module i2d_char_emit import i2d_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              num_valid_i,
  output logic              num_ready_o,
  input  i2d_num_t          num_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [CharW-1:0]  text_char_o,
  output logic              is_last_o,
  output logic [CountW-1:0] char_count_o
);

  typedef enum logic [2:0] {
    EMIT_IDLE  = 3'b001,
    EMIT_SIGN  = 3'b010,
    EMIT_DIGIT = 3'b100
  } emit_state_e;

  emit_state_e               state_q, state_d;
  logic [NumDigits-1:0][3:0] digits_q, digits_d;
  logic [IdxW-1:0]           idx_q, idx_d;
  logic [CountW-1:0]         total_q, total_d;
  logic                      ovalid_q, ovalid_d;
  logic [CharW-1:0]          char_q, char_d;
  logic                      last_q, last_d;
  logic [CountW-1:0]         count_q, count_d;

  logic [IdxW-1:0]           top_idx;
  logic                      slot_free;

  // Highest nonzero digit; zero leaves one digit.
  always_comb begin
    top_idx = '0;
    for (int i = 1; i < NumDigits; i++) begin
      if (num_i.bcd[i] != 4'd0) begin
        top_idx = IdxW'(i);
      end
    end
  end

  // Output register can take a new beat.
  assign slot_free = !ovalid_q || out_ready_i;

  always_comb begin
    state_d  = state_q;
    digits_d = digits_q;
    idx_d    = idx_q;
    total_d  = total_q;
    ovalid_d = ovalid_q && !out_ready_i;
    char_d   = char_q;
    last_d   = last_q;
    count_d  = count_q;
    unique case (state_q)
      EMIT_IDLE: begin
        if (num_valid_i) begin
          digits_d = num_i.bcd;
          idx_d    = top_idx;
          total_d  = CountW'(top_idx) + CountW'(1) + CountW'(num_i.neg);
          state_d  = num_i.neg ? EMIT_SIGN : EMIT_DIGIT;
        end
      end
      EMIT_SIGN: begin
        if (slot_free) begin
          ovalid_d = 1'b1;
          char_d   = CharMinus;
          last_d   = 1'b0;
          count_d  = '0;
          state_d  = EMIT_DIGIT;
        end
      end
      EMIT_DIGIT: begin
        if (slot_free) begin
          ovalid_d = 1'b1;
          char_d   = CharW'(CharZero + CharW'(digits_q[idx_q]));
          last_d   = (idx_q == '0);
          count_d  = (idx_q == '0) ? total_q : '0;
          if (idx_q == '0) begin
            state_d = EMIT_IDLE;
          end else begin
            idx_d = IdxW'(idx_q - IdxW'(1));
          end
        end
      end
      default: state_d = EMIT_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= EMIT_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    digits_q <= digits_d;
    idx_q    <= idx_d;
    total_q  <= total_d;
    char_q   <= char_d;
    last_q   <= last_d;
    count_q  <= count_d;
  end

  assign num_ready_o  = (state_q == EMIT_IDLE);
  assign out_valid_o  = ovalid_q;
  assign text_char_o  = char_q;
  assign is_last_o    = last_q;
  assign char_count_o = count_q;

endmodule

@@ sv/int_to_decimal_ascii_unit.sv @@
// Top level: 32-bit word to decimal ASCII characters, one beat per character.
//
//   channel | direction | payload                              | handshake
//   --------+-----------+--------------------------------------+-----------------------
//   in      | input     | kind_i, value_bits_i                 | in_valid_i/in_ready_o
//   out     | output    | text_char_o, is_last_o, char_count_o | out_valid_o/out_ready_i
//
// The bit-serial converter loads a word, shifts it in bit by bit with add-3
// correction, then hands the digits to the emitter. The emitter then sends 1 to 11
// characters, one per cycle while out_ready_i is high, while the converter already
// works on the next word. With out_ready_i high, the converter sets the word rate.
// rst_ni clears both sequencers and the output valid; there is no memory to clear.
// A stalled output beat holds in its register; the converter waits once it is done.
module int_to_decimal_ascii_unit import i2d_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              kind_i,
  input  logic [WordW-1:0]  value_bits_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [CharW-1:0]  text_char_o,
  output logic              is_last_o,
  output logic [CountW-1:0] char_count_o
);

  logic     num_valid;
  logic     num_ready;
  i2d_num_t num;

  i2d_bcd_conv u_conv (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .kind_i       (kind_i),
    .value_bits_i (value_bits_i),
    .num_valid_o  (num_valid),
    .num_ready_i  (num_ready),
    .num_o        (num)
  );

  i2d_char_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .num_valid_i  (num_valid),
    .num_ready_o  (num_ready),
    .num_i        (num),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .text_char_o  (text_char_o),
    .is_last_o    (is_last_o),
    .char_count_o (char_count_o)
  );

endmodule

@@ sv/i2d_checker.sv @@
// Port-level checker for the decimal text unit, bound to the top level.
`include "assert_macros.svh"

module i2d_checker import i2d_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              kind_i,
  input logic [WordW-1:0]  value_bits_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [CharW-1:0]  text_char_o,
  input logic              is_last_o,
  input logic [CountW-1:0] char_count_o
);

  // A waiting input beat keeps valid high and its payload unchanged.
  `ASSERT_CLK(a_in_hold, clk_i, rst_ni, in_valid_i && !in_ready_o |=> in_valid_i && $stable(kind_i) && $stable(value_bits_i), "input beat changed while waiting")

  // A stalled output beat keeps its payload.
  `ASSERT_CLK(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(text_char_o) && $stable(is_last_o) && $stable(char_count_o), "output beat changed while stalled")

  // Only '-' or a decimal digit leaves the block.
  `ASSERT_CLK(a_char_set, clk_i, rst_ni, out_valid_o |-> (text_char_o == CharMinus) || (text_char_o >= CharZero && text_char_o <= CharNine), "illegal character")

  // Count shows only on the last beat, and is 1 to 11 there.
  `ASSERT_CLK(a_count, clk_i, rst_ni, out_valid_o |-> (is_last_o ? (char_count_o >= 4'd1 && char_count_o <= 4'd11) : (char_count_o == 4'd0)), "bad char_count")

  // No output beat during reset.
  `ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |-> !out_valid_o, "output valid during reset")

endmodule

bind int_to_decimal_ascii_unit i2d_checker u_i2d_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .kind_i       (kind_i),
  .value_bits_i (value_bits_i),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .text_char_o  (text_char_o),
  .is_last_o    (is_last_o),
  .char_count_o (char_count_o)
);

@@ sim/int_to_decimal_ascii_unit_test.sv @@
// Self-checking testbench for the 32-bit word to decimal ASCII text unit.
module int_to_decimal_ascii_unit_test;
  import i2d_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DecimalBase  = 10;
  localparam int unsigned RandomWords  = 205;
  localparam int unsigned DrainCycles  = 100;
  localparam int unsigned ReportLimit  = 10;

  // One expected character beat on the output channel.
  typedef struct {
    logic [CharW-1:0]  text_char;
    logic              is_last;
    logic [CountW-1:0] char_count;
  } char_beat_t;

  // One word offered on the input channel.
  typedef struct {
    logic             kind;
    logic [WordW-1:0] value_bits;
  } word_item_t;

  // Receiver stall patterns.
  typedef enum logic [1:0] {
    ReadyAlways,
    ReadyCoinFlip,
    ReadyMostlyStalled,
    ReadyEveryThird
  } ready_mode_e;

  // Decimal text predictor plus in-order compare of character beats.
  class decimal_text_scoreboard;
    char_beat_t  pending_chars[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= ReportLimit) begin
        $display("[%0t] mismatch: %s", $realtime, msg);
      end
    endfunction

    // Expand one accepted word into the characters it must produce.
    function void note_word(logic kind, logic [WordW-1:0] word);
      logic [WordW-1:0] magnitude;
      logic             negative;
      logic [3:0]       digits[NumDigits];
      int unsigned      num_digits;
      int unsigned      total;
      char_beat_t       beat;
      negative   = (kind == KindSigned) && word[WordW-1];
      // Two's complement negate wraps to itself for the most negative value,
      // which is already the right unsigned magnitude.
      magnitude  = negative ? (~word + 1'b1) : word;
      num_digits = 0;
      do begin
        digits[num_digits] = 4'(magnitude % DecimalBase);
        magnitude = magnitude / DecimalBase;
        num_digits++;
      end while (magnitude != 0);
      total = num_digits + (negative ? 1 : 0);
      if (negative) begin
        beat = '{CharMinus, 1'b0, '0};
        pending_chars.push_back(beat);
      end
      for (int i = num_digits - 1; i >= 0; i--) begin
        beat.text_char  = CharZero + CharW'(digits[i]);
        beat.is_last    = (i == 0);
        beat.char_count = (i == 0) ? CountW'(total) : '0;
        pending_chars.push_back(beat);
      end
    endfunction

    // Compare one accepted output beat with the oldest expected character.
    function void check_char(logic [CharW-1:0] text_char, logic is_last,
                             logic [CountW-1:0] char_count);
      char_beat_t exp_beat;
      if (pending_chars.size() == 0) begin
        report($sformatf("unexpected beat char=%h last=%b count=%0d",
                         text_char, is_last, char_count));
        return;
      end
      exp_beat = pending_chars.pop_front();
      if (text_char !== exp_beat.text_char || is_last !== exp_beat.is_last ||
          char_count !== exp_beat.char_count) begin
        report($sformatf("exp char=%h last=%b count=%0d, got char=%h last=%b count=%0d",
                         exp_beat.text_char, exp_beat.is_last, exp_beat.char_count,
                         text_char, is_last, char_count));
      end
    endfunction
  endclass

  logic              clk_i        = 1'b0;
  logic              rst_ni;
  logic              in_valid_i   = 1'b0;
  logic              in_ready_o;
  logic              kind_i       = KindSigned;
  logic [WordW-1:0]  value_bits_i = '0;
  logic              out_valid_o;
  logic              out_ready_i  = 1'b0;
  logic [CharW-1:0]  text_char_o;
  logic              is_last_o;
  logic [CountW-1:0] char_count_o;

  decimal_text_scoreboard text_sb = new();

  // Edge values: zero, digit-count boundaries, sign extremes.
  word_item_t directed_words[] = '{
    '{KindSigned,   32'd0},
    '{KindUnsigned, 32'd0},
    '{KindSigned,   32'd1},
    '{KindSigned,   32'd9},
    '{KindSigned,   32'd10},
    '{KindUnsigned, 32'd99},
    '{KindUnsigned, 32'd100},
    '{KindSigned,   32'hFFFF_FFFF},
    '{KindUnsigned, 32'hFFFF_FFFF},
    '{KindSigned,   32'h8000_0000},
    '{KindUnsigned, 32'h8000_0000},
    '{KindSigned,   32'h7FFF_FFFF},
    '{KindUnsigned, 32'h7FFF_FFFF},
    '{KindSigned,   32'h8000_0001},
    '{KindSigned,   32'hFFFF_FFF6},
    '{KindSigned,   32'hFFFF_FFF7},
    '{KindUnsigned, 32'd999999999},
    '{KindUnsigned, 32'd1000000000},
    '{KindSigned,   32'd1000000000},
    '{KindSigned,   32'hC465_3600},
    '{KindUnsigned, 32'd4294967286},
    '{KindSigned,   32'h5555_5555},
    '{KindUnsigned, 32'hAAAA_AAAA}
  };

  int unsigned  ready_cycle;
  ready_mode_e  ready_mode = ReadyAlways;

  int_to_decimal_ascii_unit DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .kind_i       (kind_i),
    .value_bits_i (value_bits_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .text_char_o  (text_char_o),
    .is_last_o    (is_last_o),
    .char_count_o (char_count_o)
  );

  always #5 clk_i = ~clk_i;

  // Offer one word and hold it until the beat is taken.
  task automatic send_word(input logic kind, input logic [WordW-1:0] word);
    in_valid_i   <= 1'b1;
    kind_i       <= kind;
    value_bits_i <= word;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
    text_sb.note_word(kind, word);
  endtask

  // Random word with a spread of digit counts and signs.
  function automatic logic [WordW-1:0] random_word();
    case ($urandom_range(0, 3))
      0:       return $urandom();
      1:       return $urandom_range(0, 999);
      2:       return $urandom() >> $urandom_range(0, 31);
      default: return 32'hFFFF_FFFF - $urandom_range(0, 1000);
    endcase
  endfunction

  // Receiver: check taken beats, then pick the next ready level.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      text_sb.check_char(text_char_o, is_last_o, char_count_o);
    end
    ready_cycle <= ready_cycle + 1;
    if (ready_cycle % 64 == 63) begin
      ready_mode <= ready_mode_e'($urandom_range(0, 3));
    end
    case (ready_mode)
      ReadyAlways:        out_ready_i <= 1'b1;
      ReadyCoinFlip:      out_ready_i <= 1'($urandom_range(0, 1));
      ReadyMostlyStalled: out_ready_i <= ($urandom_range(0, 3) == 0);
      default:            out_ready_i <= (ready_cycle % 3 == 0);
    endcase
  end

  // Main sequence: reset, directed words, random bursts, drain.
  initial begin
    int unsigned burst_left;
    int unsigned gap;
    ready_cycle = 0;
    // Falling reset edge at time zero clears the block before the first clock.
    rst_ni <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    burst_left = $urandom_range(1, 8);
    for (int n = 0; n < directed_words.size() + RandomWords; n++) begin
      if (n < directed_words.size()) begin
        send_word(directed_words[n].kind, directed_words[n].value_bits);
      end else begin
        send_word(1'($urandom_range(0, 1)), random_word());
      end
      burst_left--;
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
        if (gap > 0) begin
          in_valid_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
        // Occasional long bursts give stretches with no sender idling.
        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                 : $urandom_range(1, 8);
      end
    end
    in_valid_i <= 1'b0;

    while (text_sb.pending_chars.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (text_sb.pending_chars.size() != 0) begin
      text_sb.report($sformatf("%0d characters never arrived",
                               text_sb.pending_chars.size()));
    end
    if (text_sb.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
